>>> design/srrt_pkg.sv
`timescale 1ns / 1ps
package srrt_pkg;

	localparam int SAMPLE_W = 12;
	localparam int COUNT_W  = 32;

	localparam logic [SAMPLE_W-1:0] LEVEL_RESET = 12'd2048;

	// item codes carried in the mode field
	localparam logic MODE_STORE   = 1'b0;
	localparam logic MODE_TRIGGER = 1'b1;

	typedef enum logic [1:0] {
		SRCH_IDLE,
		SRCH_WALK,
		SRCH_DONE
	} srrt_state_t;

	// top level to search sequencer
	typedef struct packed {
		logic start;
		logic ack;
	} srrt_cmd_t;

	// search sequencer to top level
	typedef struct packed {
		logic idle;
		logic done;
		logic found;
	} srrt_stat_t;

endpackage

>>> design/srrt_if.sv
`timescale 1ns / 1ps
interface srrt_sample_if;
	import srrt_pkg::*;
	logic                valid;
	logic                ready;
	logic                mode;
	logic [SAMPLE_W-1:0] sample;
	logic                overflow;

	modport source (output valid, output mode, output sample, output overflow, input ready);
	modport sink   (input valid, input mode, input sample, input overflow, output ready);
endinterface

interface srrt_result_if #(parameter int IDX_W = 11);
	import srrt_pkg::*;
	logic               valid;
	logic               ready;
	logic [IDX_W-1:0]   trigger_index;
	logic               found;
	logic [COUNT_W-1:0] error_count;

	modport source (output valid, output trigger_index, output found, output error_count,
		input ready);
	modport sink   (input valid, input trigger_index, input found, input error_count,
		output ready);
endinterface

interface srrt_cfg_if;
	import srrt_pkg::*;
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] trigger_level;

	modport source (output valid, output trigger_level, input ready);
	modport sink   (input valid, input trigger_level, output ready);
endinterface

>>> design/srrt_ram.sv
`timescale 1ns / 1ps
module srrt_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 2048,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> design/srrt_search.sv
`timescale 1ns / 1ps
module srrt_search #(
	parameter int STORE_DEPTH = 2048,
	parameter int HALF_SCREEN = 64,
	localparam int IDX_W  = $clog2(STORE_DEPTH),
	localparam int FILL_W = $clog2(STORE_DEPTH + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  srrt_pkg::srrt_cmd_t            cmd,
	input  logic [IDX_W-1:0]               wptr,
	input  logic [srrt_pkg::SAMPLE_W-1:0]  level,
	input  logic [FILL_W-1:0]              fill,
	output logic                           rd_en,
	output logic [IDX_W-1:0]               rd_addr,
	input  logic [srrt_pkg::SAMPLE_W-1:0]  rd_data,
	output srrt_pkg::srrt_stat_t           stat,
	output logic [IDX_W-1:0]               index
);
	import srrt_pkg::*;

	localparam int SPAN     = STORE_DEPTH / 2;
	localparam int CNT_W    = $clog2(SPAN + 2);
	localparam int HALF_MOD = HALF_SCREEN % STORE_DEPTH;

	srrt_state_t          state_q, state_d;
	logic [IDX_W-1:0]     addr_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 valid_s1;
	logic                 last_s1;
	logic [IDX_W-1:0]     addr_s1;
	logic [SAMPLE_W-1:0]  prev_q;
	logic [IDX_W-1:0]     prev_addr_q;
	logic                 have_prev_q;
	logic                 found_q;
	logic [IDX_W-1:0]     index_q;

	logic [IDX_W:0]       start_sum;
	logic [IDX_W-1:0]     start_idx;
	logic [IDX_W-1:0]     addr_dec;
	logic [SAMPLE_W-1:0]  cur_val;
	logic                 walking;
	logic                 hit;
	logic                 finish;

	// start = newest position stepped back by half a screen, wrapped
	always_comb begin
		start_sum = {1'b0, wptr} + (IDX_W+1)'(STORE_DEPTH - HALF_MOD);
		if (start_sum >= (IDX_W+1)'(STORE_DEPTH)) begin
			start_sum = start_sum - (IDX_W+1)'(STORE_DEPTH);
		end
		start_idx = start_sum[IDX_W-1:0];
	end

	assign addr_dec = (addr_q == '0) ? IDX_W'(STORE_DEPTH - 1) : addr_q - 1'b1;

	assign walking = (state_q == SRCH_WALK);
	assign rd_en   = walking && (cnt_q <= CNT_W'(SPAN));
	assign rd_addr = addr_q;

	// entries beyond the fill count have never been written and read as zero
	assign cur_val = (FILL_W'(addr_s1) < fill) ? rd_data : '0;
	assign hit     = walking && valid_s1 && have_prev_q && (prev_q >= level) && (cur_val < level);
	assign finish  = walking && valid_s1 && (hit || last_s1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			SRCH_IDLE: begin
				if (cmd.start) begin
					state_d = SRCH_WALK;
				end
			end
			SRCH_WALK: begin
				if (finish) begin
					state_d = SRCH_DONE;
				end
			end
			SRCH_DONE: begin
				if (cmd.ack) begin
					state_d = SRCH_IDLE;
				end
			end
			default: state_d = SRCH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SRCH_IDLE;
			valid_s1    <= 1'b0;
			have_prev_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= rd_en;
			if (cmd.start) begin
				have_prev_q <= 1'b0;
			end else if (walking && valid_s1) begin
				have_prev_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= addr_q;
		last_s1 <= (cnt_q == CNT_W'(SPAN));
		if (cmd.start) begin
			addr_q  <= start_idx;
			cnt_q   <= '0;
			index_q <= start_idx;
			found_q <= 1'b0;
		end else begin
			if (rd_en) begin
				addr_q <= addr_dec;
				cnt_q  <= cnt_q + 1'b1;
			end
			if (hit) begin
				index_q <= prev_addr_q;
				found_q <= 1'b1;
			end
		end
		if (walking && valid_s1) begin
			prev_q      <= cur_val;
			prev_addr_q <= addr_s1;
		end
	end

	assign stat.idle  = (state_q == SRCH_IDLE);
	assign stat.done  = (state_q == SRCH_DONE);
	assign stat.found = found_q;
	assign index      = index_q;

endmodule

>>> design/scope_ring_rising_trigger_unit.sv
`timescale 1ns / 1ps
// Channel   Modport  Transfer moves
// samples   sink     mode, sample, overflow: store a sample or ask for a trigger search
// results   source   trigger_index, found, error_count: one per trigger search
// cfg       sink     trigger_level: threshold register, always ready
//
// Store items may arrive back to back while the search sequencer is idle.
// A trigger item walks the sample RAM through its single read port, one entry
// a cycle, over up to STORE_DEPTH/2 + 1 reads; samples.ready is low until its
// result is handed over to the output register.
// Reset is instant: a fill count marks the RAM entries not yet written, which read as zero.
// A result waits in the output register while results.ready is low; stores carry on.
module scope_ring_rising_trigger_unit #(
	parameter int STORE_DEPTH = 2048,
	parameter int HALF_SCREEN = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	srrt_sample_if.sink          samples,
	srrt_result_if.source        results,
	srrt_cfg_if.sink             cfg
);
	import srrt_pkg::*;

	localparam int IDX_W  = $clog2(STORE_DEPTH);
	localparam int FILL_W = $clog2(STORE_DEPTH + 1);

	logic [SAMPLE_W-1:0] level_q;
	logic [IDX_W-1:0]    wptr_q;
	logic [IDX_W-1:0]    wptr_next;
	logic [FILL_W-1:0]   fill_q;
	logic [COUNT_W-1:0]  err_q;

	logic                out_valid_q;
	logic [IDX_W-1:0]    out_index_q;
	logic                out_found_q;
	logic [COUNT_W-1:0]  out_err_q;

	logic                in_xfer;
	logic                store_xfer;
	logic                ram_re;
	logic [IDX_W-1:0]    ram_raddr;
	logic [SAMPLE_W-1:0] ram_rdata;
	logic [IDX_W-1:0]    srch_index;
	srrt_cmd_t           cmd;
	srrt_stat_t          stat;

	// threshold register: writes must come only while idle, which the block does not enforce; always take them
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= LEVEL_RESET;
		end else if (cfg.valid) begin
			level_q <= cfg.trigger_level;
		end
	end

	// hold off new items while a search walks the RAM or waits to hand over
	assign samples.ready = stat.idle;
	assign in_xfer       = samples.valid && samples.ready;
	assign store_xfer    = in_xfer && (samples.mode == MODE_STORE);

	assign wptr_next = (wptr_q == IDX_W'(STORE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;

	// advance the write pointer, the fill count and the saturating error count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= IDX_W'(STORE_DEPTH - 1);
			fill_q <= '0;
			err_q  <= '0;
		end else if (store_xfer) begin
			wptr_q <= wptr_next;
			if (fill_q != FILL_W'(STORE_DEPTH)) begin
				fill_q <= fill_q + 1'b1;
			end
			if (samples.overflow && (err_q != '1)) begin
				err_q <= err_q + 1'b1;
			end
		end
	end

	srrt_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (STORE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (store_xfer),
		.waddr (wptr_next),
		.wdata (samples.sample),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// search starts on a trigger transfer; hand-over once the output register is free
	assign cmd.start = in_xfer && (samples.mode == MODE_TRIGGER);
	assign cmd.ack   = stat.done && (!out_valid_q || results.ready);

	srrt_search #(
		.STORE_DEPTH (STORE_DEPTH),
		.HALF_SCREEN (HALF_SCREEN)
	) u_search (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.wptr    (wptr_q),
		.level   (level_q),
		.fill    (fill_q),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata),
		.stat    (stat),
		.index   (srch_index)
	);

	// output register: load on hand-over, drop once the result is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.ack) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ack) begin
			out_index_q <= srch_index;
			out_found_q <= stat.found;
			out_err_q   <= err_q;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.trigger_index = out_index_q;
	assign results.found         = out_found_q;
	assign results.error_count   = out_err_q;

endmodule

>>> design/srrt_checker.sv
`timescale 1ns / 1ps
module srrt_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         in_mode,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic                         out_found,
	input logic [srrt_pkg::COUNT_W-1:0] out_error_count
);
	import srrt_pkg::*;

	logic [COUNT_W-1:0] last_err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_err_q <= '0;
		end else if (out_valid && out_ready) begin
			last_err_q <= out_error_count;
		end
	end

	// a trigger transfer makes the block busy with its search
	a_busy_after_trigger: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (in_mode == MODE_TRIGGER)) |=> !in_ready)
		else $error("input still ready after trigger transfer");

	// a new result only follows a busy cycle on the input side
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a search");

	// error count never goes backward between delivered results
	a_err_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready) |-> (out_error_count >= last_err_q))
		else $error("error count decreased");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_found)
			&& $stable(out_error_count)))
		else $error("stalled result changed");

endmodule

bind scope_ring_rising_trigger_unit srrt_checker u_srrt_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (samples.valid),
	.in_ready        (samples.ready),
	.in_mode         (samples.mode),
	.out_valid       (results.valid),
	.out_ready       (results.ready),
	.out_found       (results.found),
	.out_error_count (results.error_count)
);

>>> sim/scope_ring_rising_trigger_unit_tb.sv
`timescale 1ns / 1ps
module scope_ring_rising_trigger_unit_tb;
	import srrt_pkg::*;

	localparam int DEPTH         = 2048;
	localparam int HALF          = 64;
	localparam int IDX_W         = 11;
	localparam int SPAN          = DEPTH / 2;
	localparam int ITEM_TARGET   = 900;
	localparam int IDLE_PCT      = 38;
	localparam int HOLD_OFF      = 3000;  // receiver hold-off, longer than two full searches
	localparam int SETTLE        = 8;     // cycles for a trailing store to land in the RAM
	localparam int REPORT_LIMIT  = 10;

	typedef logic [IDX_W-1:0]    ring_idx_t;
	typedef logic [SAMPLE_W-1:0] level_t;

	typedef struct packed {
		ring_idx_t          index;
		logic               found;
		logic [COUNT_W-1:0] errors;
	} trigger_hit_t;

	// Mirror of the sample ring and its trigger search, plus the queue of
	// search results still owed by the block.
	class trigger_scoreboard;
		level_t             ring [DEPTH];
		ring_idx_t          newest;
		logic [COUNT_W-1:0] overflows;
		level_t             level;
		trigger_hit_t       owed [$];
		int                 mismatches;
		int                 stores;
		int                 searches;
		int                 crossings;

		function new();
			foreach (ring[i]) ring[i] = '0;
			newest     = ring_idx_t'(DEPTH - 1);
			overflows  = '0;
			level      = LEVEL_RESET;
			mismatches = 0;
			stores     = 0;
			searches   = 0;
			crossings  = 0;
		endfunction

		function int pending();
			return owed.size();
		endfunction

		// Apply one accepted transfer on the sample channel.
		function void note_item(logic mode, level_t smp, logic ovf);
			trigger_hit_t hit;
			ring_idx_t    cur;
			ring_idx_t    older;
			if (mode == MODE_STORE) begin
				if (ovf && overflows != '1)
					overflows++;
				newest++;
				ring[newest] = smp;
				stores++;
				return;
			end
			// walk back from half a screen behind the newest sample
			hit.index  = newest - ring_idx_t'(HALF);
			hit.found  = 1'b0;
			hit.errors = overflows;
			cur        = hit.index;
			for (int k = 0; k < SPAN; k++) begin
				older = cur - 1'b1;
				if (ring[cur] >= level && ring[older] < level) begin
					hit.index = cur;
					hit.found = 1'b1;
					break;
				end
				cur = older;
			end
			searches++;
			if (hit.found)
				crossings++;
			owed.push_back(hit);
		endfunction

		function void flag(string what);
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("[%0t] %s", $time, what);
		endfunction

		// Compare one accepted result with the oldest owed search.
		function void check_result(trigger_hit_t got);
			trigger_hit_t want;
			if (owed.size() == 0) begin
				flag($sformatf("result with no search pending: index %0d found %0b errors %0d",
					got.index, got.found, got.errors));
				return;
			end
			want = owed.pop_front();
			if (got.index !== want.index || got.found !== want.found
					|| got.errors !== want.errors)
				flag($sformatf("search result: expected index %0d found %0b errors %0d, got index %0d found %0b errors %0d",
					want.index, want.found, want.errors, got.index, got.found, got.errors));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	srrt_sample_if                     samples_ch ();
	srrt_result_if #(.IDX_W(IDX_W))    results_ch ();
	srrt_cfg_if                        cfg_ch ();

	scope_ring_rising_trigger_unit #(
		.STORE_DEPTH(DEPTH),
		.HALF_SCREEN(HALF)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples_ch),
		.results(results_ch),
		.cfg    (cfg_ch)
	);

	always #2 clk = ~clk;

	trigger_scoreboard board;
	bit                steady;         // no idling on either side while set
	int                hold_requests;  // bumped to ask the receiver for a long hold-off
	int                sent;
	int                level_writes;

	// Offer one item on the sample channel, with random idle cycles ahead of it,
	// and hold it until the transfer completes.
	task automatic offer_item(input logic mode, input level_t smp, input logic ovf);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			samples_ch.valid <= 1'b0;
			@(posedge clk);
		end
		samples_ch.valid    <= 1'b1;
		samples_ch.mode     <= mode;
		samples_ch.sample   <= smp;
		samples_ch.overflow <= ovf;
		do
			@(posedge clk);
		while (!samples_ch.ready);
		board.note_item(mode, smp, ovf);
		sent++;
	endtask

	// Trigger requests carry random payload: the block must ignore it.
	task automatic offer_trigger();
		offer_item(MODE_TRIGGER, level_t'($urandom), 1'($urandom_range(1)));
	endtask

	// Drop valid and wait until every owed search result has come back.
	task automatic drain();
		samples_ch.valid <= 1'b0;
		@(posedge clk);
		while (board.pending() > 0)
			@(posedge clk);
	endtask

	// Write the threshold only while the block is idle.
	task automatic set_level(input level_t value);
		drain();
		repeat (SETTLE) @(posedge clk);
		cfg_ch.valid         <= 1'b1;
		cfg_ch.trigger_level <= value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		board.level = value;
		level_writes++;
	endtask

	// Sample values at or above the threshold; lean on the threshold itself.
	function automatic level_t pick_high();
		if ($urandom_range(99) < 30)
			return board.level;
		return level_t'(board.level + $urandom_range(4095 - board.level));
	endfunction

	// Sample values below the threshold; lean on one under it.
	function automatic level_t pick_low();
		if (board.level == 0)
			return '0;
		if ($urandom_range(99) < 30)
			return board.level - 1'b1;
		return level_t'($urandom_range(board.level - 1));
	endfunction

	// Capture a stretch of waveform: square, sawtooth, chatter about the
	// threshold, or plain noise.
	task automatic wave_burst(input int n);
		int     period;
		int     offset;
		int     shape;
		int     pos;
		level_t hi;
		level_t lo;
		level_t smp;
		period = $urandom_range(40, 2);
		offset = $urandom_range(period - 1);
		shape  = $urandom_range(3);
		hi     = pick_high();
		lo     = pick_low();
		for (int i = 0; i < n; i++) begin
			pos = (i + offset) % period;
			case (shape)
				0: smp = (pos < period / 2) ? lo : hi;
				1: smp = level_t'((pos * 4095) / (period - 1));
				2: smp = $urandom_range(1) ? pick_high() : pick_low();
				default: smp = level_t'($urandom);
			endcase
			offer_item(MODE_STORE, smp, $urandom_range(99) < 10);
		end
	endtask

	// Mostly captures followed by trigger requests, with a share of lone items.
	task automatic random_phase(input int quota);
		int goal;
		goal = sent + quota;
		while (sent < goal) begin
			if ($urandom_range(99) < 15) begin
				if ($urandom_range(1))
					offer_trigger();
				else
					offer_item(MODE_STORE, level_t'($urandom), 1'($urandom_range(1)));
			end else begin
				wave_burst($urandom_range(100, 4));
				repeat ($urandom_range(3, 1)) offer_trigger();
			end
		end
	endtask

	// Result side: check every transfer, then choose ready for the next edge.
	initial begin
		int hold_left;
		int hold_served;
		hold_left   = 0;
		hold_served = 0;
		results_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (results_ch.valid && results_ch.ready)
				board.check_result('{results_ch.trigger_index, results_ch.found,
					results_ch.error_count});
			if (hold_left == 0 && hold_served != hold_requests) begin
				hold_served = hold_requests;
				hold_left   = HOLD_OFF;
			end
			if (hold_left > 0) begin
				hold_left--;
				results_ch.ready <= 1'b0;
			end else begin
				results_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	initial begin
		board         = new();
		steady        = 1'b0;
		hold_requests = 0;
		sent          = 0;
		level_writes  = 0;
		arst_n               = 1'b0;
		samples_ch.valid    <= 1'b0;
		samples_ch.mode     <= MODE_STORE;
		samples_ch.sample   <= '0;
		samples_ch.overflow <= 1'b0;
		cfg_ch.valid        <= 1'b0;
		cfg_ch.trigger_level <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: search an empty store, so fall back to the start index.
		offer_trigger();
		// Extremes of the sample, threshold and its neighbour, overflow flags.
		offer_item(MODE_STORE, 12'd0, 1'b0);
		offer_item(MODE_STORE, 12'd4095, 1'b1);
		offer_item(MODE_STORE, 12'd2047, 1'b1);
		offer_item(MODE_STORE, 12'd2048, 1'b0);
		// Trigger payload must leave the store, pointer and counter alone.
		offer_item(MODE_TRIGGER, 12'd4095, 1'b1);
		offer_item(MODE_TRIGGER, 12'd0, 1'b0);
		offer_item(MODE_STORE, 12'hAAA, 1'b1);
		offer_item(MODE_STORE, 12'h555, 1'b0);
		offer_trigger();
		// Threshold at zero: nothing can sit below it, so never a crossing.
		set_level(12'd0);
		offer_item(MODE_STORE, 12'd0, 1'b0);
		offer_item(MODE_STORE, 12'd4095, 1'b1);
		offer_trigger();
		// Threshold at full scale: only a full-scale sample can cross.
		set_level(12'd4095);
		offer_item(MODE_STORE, 12'd4094, 1'b0);
		offer_item(MODE_STORE, 12'd4095, 1'b0);
		offer_trigger();

		// Mid-scale threshold with both sides running flat out.
		set_level(LEVEL_RESET);
		steady = 1'b1;
		random_phase(150);
		steady = 1'b0;

		set_level(12'd0);
		random_phase(60);

		// Hold the receiver off and keep offering: a result waits in the output
		// register, the next search cannot hand over its result, and the sample side stalls.
		set_level(12'd4095);
		hold_requests++;
		repeat (4) begin
			wave_burst($urandom_range(30, 10));
			offer_trigger();
		end
		random_phase(100);

		set_level(12'd1);
		random_phase(120);

		set_level(level_t'($urandom));
		random_phase(80);
		// pause the sender until every owed result is in, then carry on
		drain();
		random_phase(70);

		set_level(level_t'($urandom));
		random_phase(60);

		set_level(LEVEL_RESET);
		while (sent < ITEM_TARGET)
			random_phase(50);

		drain();
		repeat (16) @(posedge clk);
		if (board.pending() > 0)
			board.flag($sformatf("%0d search results never arrived", board.pending()));

		$display("Run covered %0d items: %0d samples stored, %0d trigger searches, %0d crossings found",
			sent, board.stores, board.searches, board.crossings);
		$display("%0d threshold writes, %0d overflow flags counted, %0d mismatches",
			level_writes, board.overflows, board.mismatches);
		if (board.mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog: several times the slowest legal run.
	initial begin
		#20_000_000;
		$display("Timeout with %0d search results owed", board.pending());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
